// File: hw/rtl/dpbe_pkg.sv
// Shared constants and table-building functions for the dot-product ELU neuron.
package dpbe_pkg;

    localparam int ACC_WIDTH_DEFAULT   = 48;
    localparam int ELU_ENTRIES_DEFAULT = 256;

    localparam int DATA_W  = 16;        // activation, weight, bias, result
    localparam int PROD_W  = 2 * DATA_W;
    localparam int BIAS_SHIFT = 12;     // Q7.8 -> Q.20
    localparam int ROUND_SHIFT = 12;    // Q.20 -> Q7.8
    localparam int ELU_MAG_W = 23;      // 8.0 in Q.20 is 2^23
    localparam int Q30_SHIFT = 30;

    localparam logic signed [DATA_W-1:0] RES_MAX     = 16'sh7fff;
    localparam logic signed [DATA_W-1:0] RES_MIN     = 16'sh8000;
    localparam logic signed [DATA_W-1:0] ELU_NEG_ONE = 16'shff00;

    // Entry idx: exp(-idx*h) - 1 in Q7.8, powers rounded half up in Q.30
    function automatic logic signed [DATA_W-1:0] elu_entry(longint unsigned base, int idx);
        longint unsigned p;
        longint          e;
        p = longint'(1) << Q30_SHIFT;
        for (int i = 0; i < idx; i++) begin
            p = (p * base + (longint'(1) << 29)) >> Q30_SHIFT;
        end
        e = longint'((p + (longint'(1) << 21)) >> 22) - 256;
        return DATA_W'(e);
    endfunction

endpackage

// File: hw/rtl/dpbe_mac.sv
// Input register, multiplier, bias alignment and accumulator stages.
module dpbe_mac #(
    parameter int ACC_WIDTH = dpbe_pkg::ACC_WIDTH_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [dpbe_pkg::DATA_W-1:0]  in_activation,
    input  logic signed [dpbe_pkg::DATA_W-1:0]  in_weight,
    input  logic signed [dpbe_pkg::DATA_W-1:0]  in_bias,
    input  logic                                in_last,
    output logic                                sum_valid,
    input  logic                                sum_ready,
    output logic signed [ACC_WIDTH-1:0]         sum_value
);

    // stage 1: input word
    logic                               s1_valid_reg;
    logic signed [dpbe_pkg::DATA_W-1:0] s1_act_reg;
    logic signed [dpbe_pkg::DATA_W-1:0] s1_wgt_reg;
    logic signed [dpbe_pkg::DATA_W-1:0] s1_bias_reg;
    logic                               s1_last_reg;

    // stage 2: product
    logic                               s2_valid_reg;
    logic signed [dpbe_pkg::PROD_W-1:0] s2_prod_reg;
    logic signed [dpbe_pkg::DATA_W-1:0] s2_bias_reg;
    logic                               s2_last_reg;
    logic signed [dpbe_pkg::PROD_W-1:0] prod_next;

    // stage 3: term to accumulate
    logic                               s3_valid_reg;
    logic signed [ACC_WIDTH-1:0]        s3_term_reg;
    logic                               s3_last_reg;
    logic signed [ACC_WIDTH-1:0]        term_next;

    logic signed [ACC_WIDTH-1:0]        acc_reg;
    logic signed [ACC_WIDTH-1:0]        acc_next;
    logic                               sum_valid_reg;
    logic signed [ACC_WIDTH-1:0]        sum_reg;

    logic sum_free;
    logic s3_go;
    logic s3_free;
    logic s2_free;

    assign sum_free = !sum_valid_reg || sum_ready;
    // a non-last term only folds into the accumulator, it never waits
    assign s3_go    = s3_valid_reg && (!s3_last_reg || sum_free);
    assign s3_free  = !s3_valid_reg || s3_go;
    assign s2_free  = !s2_valid_reg || s3_free;
    assign in_ready = !s1_valid_reg || s2_free;

    assign prod_next = s1_act_reg * s1_wgt_reg;
    assign term_next = ACC_WIDTH'(s2_prod_reg)
                     + (s2_last_reg ? (ACC_WIDTH'(s2_bias_reg) <<< dpbe_pkg::BIAS_SHIFT)
                                    : ACC_WIDTH'(0));
    assign acc_next  = acc_reg + s3_term_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            sum_valid_reg <= 1'b0;
            acc_reg       <= '0;
        end
        else
        begin
            if (in_ready)
                s1_valid_reg <= in_valid;
            if (s2_free)
                s2_valid_reg <= s1_valid_reg;
            if (s3_free)
                s3_valid_reg <= s2_valid_reg;
            if (sum_free)
                sum_valid_reg <= s3_go && s3_last_reg;
            if (s3_go)
                acc_reg <= s3_last_reg ? '0 : acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_act_reg  <= in_activation;
            s1_wgt_reg  <= in_weight;
            s1_bias_reg <= in_bias;
            s1_last_reg <= in_last;
        end
        if (s1_valid_reg && s2_free)
        begin
            s2_prod_reg <= prod_next;
            s2_bias_reg <= s1_bias_reg;
            s2_last_reg <= s1_last_reg;
        end
        if (s2_valid_reg && s3_free)
        begin
            s3_term_reg <= term_next;
            s3_last_reg <= s2_last_reg;
        end
        if (s3_go && s3_last_reg)
            sum_reg <= acc_next;
    end

    assign sum_valid = sum_valid_reg;
    assign sum_value = sum_reg;

endmodule

// File: hw/rtl/dpbe_post.sv
// ELU table lookup, rounding to Q7.8, saturation and the output register.
module dpbe_post #(
    parameter int ACC_WIDTH         = dpbe_pkg::ACC_WIDTH_DEFAULT,
    parameter int ELU_TABLE_ENTRIES = dpbe_pkg::ELU_ENTRIES_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                act_enable,
    input  logic                                sum_valid,
    output logic                                sum_ready,
    input  logic signed [ACC_WIDTH-1:0]         sum_value,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [dpbe_pkg::DATA_W-1:0]  out_result,
    output logic                                out_saturated
);

    localparam int MAG_W = dpbe_pkg::ELU_MAG_W;
    localparam int CNT_W = $clog2(ELU_TABLE_ENTRIES + 1);
    localparam int IDX_W = $clog2(ELU_TABLE_ENTRIES);
    localparam int SCL_W = MAG_W + CNT_W;
    localparam int RND_W = ACC_WIDTH + 1 - dpbe_pkg::ROUND_SHIFT;
    localparam int RES_W = dpbe_pkg::DATA_W;
    localparam int QS    = dpbe_pkg::Q30_SHIFT;
    localparam longint unsigned ELU_STEP = (64'd8 << 30) / ELU_TABLE_ENTRIES;

    // exp(-h) in Q.30 from a 20-term Taylor series with truncating products
    localparam longint unsigned Q30_ONE = 64'd1 << QS;
    localparam longint unsigned ELU_T1  = ((Q30_ONE * ELU_STEP) >> QS) / 1;
    localparam longint unsigned ELU_T2  = ((ELU_T1  * ELU_STEP) >> QS) / 2;
    localparam longint unsigned ELU_T3  = ((ELU_T2  * ELU_STEP) >> QS) / 3;
    localparam longint unsigned ELU_T4  = ((ELU_T3  * ELU_STEP) >> QS) / 4;
    localparam longint unsigned ELU_T5  = ((ELU_T4  * ELU_STEP) >> QS) / 5;
    localparam longint unsigned ELU_T6  = ((ELU_T5  * ELU_STEP) >> QS) / 6;
    localparam longint unsigned ELU_T7  = ((ELU_T6  * ELU_STEP) >> QS) / 7;
    localparam longint unsigned ELU_T8  = ((ELU_T7  * ELU_STEP) >> QS) / 8;
    localparam longint unsigned ELU_T9  = ((ELU_T8  * ELU_STEP) >> QS) / 9;
    localparam longint unsigned ELU_T10 = ((ELU_T9  * ELU_STEP) >> QS) / 10;
    localparam longint unsigned ELU_T11 = ((ELU_T10 * ELU_STEP) >> QS) / 11;
    localparam longint unsigned ELU_T12 = ((ELU_T11 * ELU_STEP) >> QS) / 12;
    localparam longint unsigned ELU_T13 = ((ELU_T12 * ELU_STEP) >> QS) / 13;
    localparam longint unsigned ELU_T14 = ((ELU_T13 * ELU_STEP) >> QS) / 14;
    localparam longint unsigned ELU_T15 = ((ELU_T14 * ELU_STEP) >> QS) / 15;
    localparam longint unsigned ELU_T16 = ((ELU_T15 * ELU_STEP) >> QS) / 16;
    localparam longint unsigned ELU_T17 = ((ELU_T16 * ELU_STEP) >> QS) / 17;
    localparam longint unsigned ELU_T18 = ((ELU_T17 * ELU_STEP) >> QS) / 18;
    localparam longint unsigned ELU_T19 = ((ELU_T18 * ELU_STEP) >> QS) / 19;
    localparam longint unsigned ELU_T20 = ((ELU_T19 * ELU_STEP) >> QS) / 20;
    localparam longint ELU_SUM = longint'(Q30_ONE)
        - longint'(ELU_T1)  + longint'(ELU_T2)  - longint'(ELU_T3)  + longint'(ELU_T4)
        - longint'(ELU_T5)  + longint'(ELU_T6)  - longint'(ELU_T7)  + longint'(ELU_T8)
        - longint'(ELU_T9)  + longint'(ELU_T10) - longint'(ELU_T11) + longint'(ELU_T12)
        - longint'(ELU_T13) + longint'(ELU_T14) - longint'(ELU_T15) + longint'(ELU_T16)
        - longint'(ELU_T17) + longint'(ELU_T18) - longint'(ELU_T19) + longint'(ELU_T20);
    localparam longint unsigned ELU_BASE = (ELU_SUM < 0) ? 64'd0 : 64'(ELU_SUM);
    localparam logic signed [ACC_WIDTH-1:0] ELU_FLOOR = ACC_WIDTH'(-(64'sd1 <<< MAG_W));

    logic signed [RES_W-1:0] elu_rom [ELU_TABLE_ENTRIES];

    for (genvar gi = 0; gi < ELU_TABLE_ENTRIES; gi++)
    begin : g_rom
        localparam logic signed [RES_W-1:0] ENTRY = dpbe_pkg::elu_entry(ELU_BASE, gi);
        assign elu_rom[gi] = ENTRY;
    end

    logic signed [ACC_WIDTH-1:0] neg_sum;
    logic [MAG_W-1:0]            mag;
    logic [SCL_W-1:0]            scaled;
    logic [CNT_W-1:0]            idx_raw;
    logic [IDX_W-1:0]            idx;
    logic                        below_range;
    logic                        non_positive;
    logic signed [ACC_WIDTH:0]   biased;
    logic signed [RND_W-1:0]     rounded;
    logic                        sat_hi;
    logic                        sat_lo;
    logic signed [RES_W-1:0]     result_next;
    logic                        sat_next;

    logic                        out_valid_reg;
    logic signed [RES_W-1:0]     result_reg;
    logic                        sat_reg;

    // ELU index: floor(-x * entries / 8.0)
    assign neg_sum = -sum_value;
    assign mag     = neg_sum[MAG_W-1:0];
    assign scaled  = SCL_W'(mag) * SCL_W'(ELU_TABLE_ENTRIES);
    assign idx_raw = scaled[SCL_W-1:MAG_W];
    assign idx     = (idx_raw >= CNT_W'(ELU_TABLE_ENTRIES)) ? IDX_W'(ELU_TABLE_ENTRIES - 1)
                                                            : idx_raw[IDX_W-1:0];

    assign below_range  = sum_value <= ELU_FLOOR;
    assign non_positive = sum_value[ACC_WIDTH-1] || (sum_value == '0);

    // round half up, then clip to Q7.8
    assign biased  = {sum_value[ACC_WIDTH-1], sum_value}
                   + (ACC_WIDTH+1)'(1 << (dpbe_pkg::ROUND_SHIFT - 1));
    assign rounded = $signed(biased[ACC_WIDTH:dpbe_pkg::ROUND_SHIFT]);
    assign sat_hi  = !rounded[RND_W-1] && (rounded[RND_W-1:RES_W-1] != '0);
    assign sat_lo  = rounded[RND_W-1] && (rounded[RND_W-1:RES_W-1] != '1);

    always_comb
    begin
        sat_next = 1'b0;
        if (act_enable && non_positive)
        begin
            result_next = below_range ? dpbe_pkg::ELU_NEG_ONE : elu_rom[idx];
        end
        else if (sat_hi)
        begin
            result_next = dpbe_pkg::RES_MAX;
            sat_next    = 1'b1;
        end
        else if (sat_lo)
        begin
            result_next = dpbe_pkg::RES_MIN;
            sat_next    = 1'b1;
        end
        else
        begin
            result_next = rounded[RES_W-1:0];
        end
    end

    assign sum_ready = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (sum_ready)
            out_valid_reg <= sum_valid;
    end

    always_ff @(posedge clk)
    begin
        if (sum_valid && sum_ready)
        begin
            result_reg <= result_next;
            sat_reg    <= sat_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_result    = result_reg;
    assign out_saturated = sat_reg;

endmodule

// File: hw/rtl/dot_product_bias_elu_neuron.sv
// Top level of the multiply-accumulate neuron with bias, optional ELU and Q7.8 output.
//
// Usage:
//   Stream one activation/weight pair per word on the s_axis channel; tdata
//   carries activation (Q7.8), weight (Q3.12) and bias (Q7.8), tlast closes
//   the dot product. Only the closing word's bias is used. Words without
//   tlast produce nothing on the output; each closing word produces one
//   m_axis word: the Q7.8 neuron result in tdata and the saturation flag in
//   tuser. The accumulator clears after every closing word.
//   cfg_we/cfg_wdata write activation_enable (1 = ELU, 0 = bypass); write it
//   only while no dot product is in flight.
// Timing:
//   One word accepted per cycle while the output is taken. A closing word
//   passes the input register, 16x16 multiplier, bias alignment add,
//   accumulator add, then ELU/round/saturate into the output register.
// Reset: empties the pipeline, clears the accumulator, sets activation_enable.
// Stall: a held output word keeps its value; words keep entering until the
//   pipeline stages behind the output register fill, then s_axis_tready drops.
module dot_product_bias_elu_neuron #(
    parameter int ACC_WIDTH         = dpbe_pkg::ACC_WIDTH_DEFAULT,
    parameter int ELU_TABLE_ENTRIES = dpbe_pkg::ELU_ENTRIES_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,       // activation_enable
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,    // activation[15:0], weight[31:16], bias[47:32]
    input  logic        s_axis_tlast,    // last_term
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,    // result[15:0]
    output logic        m_axis_tuser     // saturated
);

    logic                               act_enable_reg;
    logic                               sum_valid;
    logic                               sum_ready;
    logic signed [ACC_WIDTH-1:0]        sum_value;
    logic signed [dpbe_pkg::DATA_W-1:0] result;

    // hold the activation mode; reset selects ELU
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            act_enable_reg <= 1'b1;
        else if (cfg_we)
            act_enable_reg <= cfg_wdata;
    end

    // multiply and accumulate; one biased sum leaves per closing word
    dpbe_mac #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_mac (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_axis_tvalid),
        .in_ready      (s_axis_tready),
        .in_activation ($signed(s_axis_tdata[15:0])),
        .in_weight     ($signed(s_axis_tdata[31:16])),
        .in_bias       ($signed(s_axis_tdata[47:32])),
        .in_last       (s_axis_tlast),
        .sum_valid     (sum_valid),
        .sum_ready     (sum_ready),
        .sum_value     (sum_value)
    );

    // apply ELU or round/saturate, then drive the output register
    dpbe_post #(
        .ACC_WIDTH         (ACC_WIDTH),
        .ELU_TABLE_ENTRIES (ELU_TABLE_ENTRIES)
    ) u_post (
        .clk           (clk),
        .rst_n         (rst_n),
        .act_enable    (act_enable_reg),
        .sum_valid     (sum_valid),
        .sum_ready     (sum_ready),
        .sum_value     (sum_value),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .out_result    (result),
        .out_saturated (m_axis_tuser)
    );

    assign m_axis_tdata = result;

endmodule

// File: hw/rtl/dpbe_checker.sv
// Port-level assertions for the neuron, bound to the top level.
module dpbe_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    // hold a stalled output word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output word dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("output word changed while stalled");

    // a flagged result sits on one of the rails
    a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 16'h7fff || m_axis_tdata == 16'h8000)
        else $error("saturated result off the rails");

    // with the output register empty the pipeline never backs up
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

endmodule

bind dot_product_bias_elu_neuron dpbe_checker u_dpbe_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// File: tb/sv/tb_dot_product_bias_elu_neuron.sv
// Self-checking testbench for the dot-product neuron with bias, optional ELU and Q7.8 output.
module tb_dot_product_bias_elu_neuron;

    localparam int ACC_W      = 48;
    localparam int ELU_N      = 256;
    localparam int HALF_CLK   = 6;
    localparam int SETTLE_CYC = 8;         // slack after the last queued result
    localparam int HOLD_CYC   = 300;       // long receiver hold-off in the pressure phase
    localparam int PHASE_WORDS = 100;
    localparam longint LIMIT_CYC = 1_500_000;

    typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

    // one input word, fields as the block sees them
    typedef struct {
        logic signed [15:0] act;   // Q7.8
        logic signed [15:0] wgt;   // Q3.12
        logic signed [15:0] bias;  // Q7.8, used on the closing word only
        logic               last;
    } term_t;

    typedef struct {
        logic [15:0] res;
        logic        sat;
    } neuron_out_t;

    // directed row: elu setting, word fields, repeat count, optional typed result
    typedef struct packed {
        logic        elu;
        logic [15:0] act;
        logic [15:0] wgt;
        logic [15:0] bias;
        logic        last;
        logic [17:0] reps;
        logic        typed;
        logic [15:0] res;
        logic        sat;
    } plan_row_t;

    localparam int PLAN_ROWS = 22;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_wdata = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;    // activation[15:0], weight[31:16], bias[47:32]
    logic        s_axis_tlast = 1'b0;  // last_term
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;         // result[15:0]
    logic        m_axis_tuser;         // saturated

    // predictor state
    logic [ACC_W-1:0]   acc_q20 = '0;
    logic               elu_on = 1'b1;
    logic signed [15:0] elu_lut [ELU_N];

    neuron_out_t pending_outputs [$];
    int          mismatches = 0;

    // idling controls, driven by the stimulus process, read by the receiver
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_reqs = 0;
    int hold_seen = 0;
    int hold_left = 0;

    plan_row_t plan [PLAN_ROWS];

    dot_product_bias_elu_neuron DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #HALF_CLK clk = ~clk;

    // Hard stop in case the block hangs.
    initial
    begin
        #(longint'(2 * HALF_CLK) * LIMIT_CYC);
        $display("FAILURE");
        $finish;
    end

    // exp(-i*h)-1 in Q7.8 for i in [0, ELU_N), h = 8/ELU_N.
    // Form exp(-h) in Q.30 from a truncated 20-term series, then raise it by
    // repeated multiplication, rounding each power half up.
    function automatic void build_elu_lut();
        longint unsigned step_q30;
        longint unsigned term;
        longint unsigned pw;
        longint          decay;
        step_q30 = (64'd8 << 30) / ELU_N;
        term = 64'd1 << 30;
        decay = longint'(64'd1 << 30);
        for (int k = 1; k <= 20; k++)
        begin
            term = ((term * step_q30) >> 30) / longint'(k);
            if (k % 2 == 1)
                decay = decay - longint'(term);
            else
                decay = decay + longint'(term);
        end
        if (decay < 0)
            decay = 0;
        pw = 64'd1 << 30;
        for (int i = 0; i < ELU_N; i++)
        begin
            elu_lut[i] = 16'(longint'((pw + (64'd1 << 21)) >> 22) - 256);
            pw = (pw * longint'(decay) + (64'd1 << 29)) >> 30;
        end
    endfunction

    // Advance the accumulator by one word; on a closing word, produce the
    // neuron output and clear the accumulator.
    function automatic bit neuron_predict(input term_t t, output neuron_out_t r);
        longint prod;
        longint bias_q20;
        longint v;
        longint q;
        longint mag;
        logic   sat;
        prod = longint'(t.act) * longint'(t.wgt);
        acc_q20 = acc_q20 + ACC_W'(prod);
        r = '{res: '0, sat: 1'b0};
        if (!t.last)
            return 1'b0;
        bias_q20 = longint'(t.bias) <<< 12;
        acc_q20 = acc_q20 + ACC_W'(bias_q20);
        v = $signed(acc_q20);
        acc_q20 = '0;
        sat = 1'b0;
        if (elu_on && v <= 0)
        begin
            // at or below -8.0 the curve is flat at -1.0
            if (v <= -(longint'(8) <<< 20))
                q = -256;
            else
            begin
                mag = -v;
                q = elu_lut[int'((mag * ELU_N) >>> 23)];
            end
        end
        else
        begin
            q = ((v >>> 11) + 1) >>> 1;   // round half up to Q7.8
            if (q > 32767)
            begin
                q = 32767;
                sat = 1'b1;
            end
            else if (q < -32768)
            begin
                q = -32768;
                sat = 1'b1;
            end
        end
        r.res = q[15:0];
        r.sat = sat;
        return 1'b1;
    endfunction

    function automatic logic signed [15:0] rand_signed(int bits);
        logic signed [15:0] r;
        int                 s;
        s = 16 - bits;
        r = 16'($urandom);
        return (r <<< s) >>> s;
    endfunction

    // Offer one word until taken; queue the result it causes. A typed result
    // from the directed table takes the place of the predicted one.
    task automatic push_word(input term_t t, input bit typed, input neuron_out_t typed_out);
        neuron_out_t predicted;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {t.bias, t.wgt, t.act};
        s_axis_tlast  <= t.last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (neuron_predict(t, predicted))
            pending_outputs = {pending_outputs, (typed ? typed_out : predicted)};
    endtask

    // Sometimes drop valid for a while, at the current sender idle rate.
    task automatic sender_pause();
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
    endtask

    // Hold the input and wait for every queued result, then for a settling margin.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_outputs.size() != 0);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic write_elu_enable(input logic on);
        cfg_we    <= 1'b1;
        cfg_wdata <= on;
        @(posedge clk);
        cfg_we <= 1'b0;
        elu_on = on;
    endtask

    task automatic report_mismatch(input string what);
        if (mismatches < 10)
            $display("mismatch at %0t: %s", $realtime, what);
        mismatches++;
    endtask

    // Receiver: check each taken result against the oldest expectation, then
    // choose the next ready value. A hold request blocks the output for a long
    // stretch so the pipeline backs up into the input.
    always @(posedge clk)
    begin
        neuron_out_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_outputs.size() == 0)
                report_mismatch($sformatf("unexpected word result=%h sat=%b",
                                          m_axis_tdata, m_axis_tuser));
            else
            begin
                want = pending_outputs.pop_front();
                if (m_axis_tdata !== want.res)
                    report_mismatch($sformatf("result expected %h got %h",
                                              want.res, m_axis_tdata));
                if (m_axis_tuser !== want.sat)
                    report_mismatch($sformatf("saturated expected %b got %b (result %h)",
                                              want.sat, m_axis_tuser, want.res));
            end
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (hold_reqs != hold_seen)
        begin
            hold_seen = hold_reqs;
            hold_left = HOLD_CYC;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    initial
    begin
        term_t       t;
        neuron_out_t typed_out;
        idle_mode_t  mode;
        logic        cur_on;
        int          words;
        int          len;
        int          flavor;
        int          bits_act;
        int          bits_wgt;
        int          bits_bias;

        // elu, act, wgt, bias, last, reps, typed, result, saturated
        plan = '{
            // ELU on, as after reset
            '{1'b1, 16'h0000, 16'h0000, 16'h0000, 1'b1, 18'd1, 1'b1, 16'h0000, 1'b0},
            '{1'b1, 16'h0100, 16'h1000, 16'h0000, 1'b1, 18'd1, 1'b1, 16'h0100, 1'b0},
            '{1'b1, 16'h8000, 16'h8000, 16'h0000, 1'b1, 18'd1, 1'b1, 16'h7fff, 1'b1},
            '{1'b1, 16'h8000, 16'h7fff, 16'h0000, 1'b1, 18'd1, 1'b1, 16'hff00, 1'b0},
            // exactly -8.0, then one LSB above it (top table entry)
            '{1'b1, 16'hf800, 16'h1000, 16'h0000, 1'b1, 18'd1, 1'b1, 16'hff00, 1'b0},
            '{1'b1, 16'hf801, 16'h1000, 16'h0000, 1'b1, 18'd1, 1'b0, 16'h0000, 1'b0},
            '{1'b1, 16'h0000, 16'h0000, 16'h8000, 1'b1, 18'd1, 1'b1, 16'hff00, 1'b0},
            // bias on open words is ignored
            '{1'b1, 16'h7fff, 16'h7fff, 16'h1234, 1'b0, 18'd3, 1'b0, 16'h0000, 1'b0},
            '{1'b1, 16'h8000, 16'h7fff, 16'hffff, 1'b1, 18'd1, 1'b0, 16'h0000, 1'b0},
            '{1'b1, 16'hff00, 16'h1000, 16'h0000, 1'b1, 18'd1, 1'b0, 16'h0000, 1'b0},
            '{1'b1, 16'hffff, 16'h0001, 16'h0000, 1'b1, 18'd1, 1'b0, 16'h0000, 1'b0},
            // a long run of full-scale products builds a large positive sum
            '{1'b1, 16'h8000, 16'h8000, 16'h0000, 1'b0, 18'd40, 1'b0, 16'h0000, 1'b0},
            '{1'b1, 16'h8000, 16'h8000, 16'h0000, 1'b1, 18'd1, 1'b0, 16'h0000, 1'b0},
            // ELU bypassed
            '{1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b1, 18'd1, 1'b1, 16'h0000, 1'b0},
            '{1'b0, 16'h8000, 16'h8000, 16'h0000, 1'b1, 18'd1, 1'b1, 16'h7fff, 1'b1},
            '{1'b0, 16'h8000, 16'h7fff, 16'h0000, 1'b1, 18'd1, 1'b1, 16'h8000, 1'b1},
            '{1'b0, 16'h0000, 16'h0000, 16'h7fff, 1'b1, 18'd1, 1'b1, 16'h7fff, 1'b0},
            '{1'b0, 16'h0000, 16'h0000, 16'h8000, 1'b1, 18'd1, 1'b1, 16'h8000, 1'b0},
            // half an LSB rounds up on both signs
            '{1'b0, 16'h0001, 16'h0800, 16'h0000, 1'b1, 18'd1, 1'b1, 16'h0001, 1'b0},
            '{1'b0, 16'hffff, 16'h0800, 16'h0000, 1'b1, 18'd1, 1'b1, 16'h0000, 1'b0},
            '{1'b0, 16'hff00, 16'h1000, 16'h0000, 1'b1, 18'd1, 1'b1, 16'hff00, 1'b0},
            // ELU back on, small positive sum with bias
            '{1'b1, 16'h0080, 16'h1000, 16'h0100, 1'b1, 18'd1, 1'b0, 16'h0000, 1'b0}
        };

        build_elu_lut();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: change the ELU setting only between closed dot products.
        cur_on = 1'b1;
        for (int r = 0; r < PLAN_ROWS; r++)
        begin
            if (plan[r].elu != cur_on)
            begin
                settle();
                write_elu_enable(plan[r].elu);
                cur_on = plan[r].elu;
            end
            t.act  = plan[r].act;
            t.wgt  = plan[r].wgt;
            t.bias = plan[r].bias;
            t.last = plan[r].last;
            typed_out.res = plan[r].res;
            typed_out.sat = plan[r].sat;
            for (int n = 0; n < int'(plan[r].reps); n++)
                push_word(t, plan[r].typed, typed_out);
        end

        // Random phases: each one sets its own idling and ELU setting, and the
        // last one backs up the pipeline with a long output hold.
        for (int p = 0; p < 5; p++)
        begin
            settle();
            mode = idle_mode_t'(p % 4);
            send_idle_pct  <= (mode == IDLE_SEND) ? 75 : (mode == IDLE_BOTH) ? 8 : 0;
            recv_stall_pct <= (mode == IDLE_RECV) ? 75 : (mode == IDLE_BOTH) ? 8 : 0;
            write_elu_enable(p % 2 == 0);
            if (p == 4)
                hold_reqs <= hold_reqs + 1;
            words = 0;
            while (words < PHASE_WORDS)
            begin
                // mostly short dot products, a few long ones; small magnitudes
                // keep the biased sum near the ELU table range
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40)
                                                   : $urandom_range(1, 8);
                flavor    = $urandom_range(0, 3);
                bits_act  = (flavor == 0) ? 16 : (flavor == 3) ? 8 : 10;
                bits_wgt  = (flavor == 0) ? 16 : (flavor == 3) ? 12 : 13;
                bits_bias = (flavor == 0) ? 16 : (flavor == 3) ? 10 : 12;
                for (int j = 0; j < len; j++)
                begin
                    t.act  = rand_signed(bits_act);
                    t.wgt  = rand_signed(bits_wgt);
                    t.last = (j == len - 1);
                    t.bias = t.last ? rand_signed(bits_bias) : rand_signed(16);
                    push_word(t, 1'b0, typed_out);
                    words++;
                    sender_pause();
                end
            end
        end

        settle();
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
